// ----- sv/pvt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pvt_pkg
// Shared constants, register map and pipeline payload types of the
// perspective and viewport transform.
// ----------------------------------------------------------------------------
package pvt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIM_W     = 14;

  // A full product, and the product after the fraction bits are dropped.
  localparam int PROD_W = 2 * DATA_W;
  localparam int SCL_W  = PROD_W - FRAC_BITS;

  // Divider widths: dividend magnitude, divisor magnitude, quotient.
  localparam int NUM_W = PROD_W - 1;
  localparam int DEN_W = SCL_W;
  localparam int Q_W   = DATA_W;
  localparam int QB_W  = $clog2(Q_W);
  localparam int CMP_W = DEN_W + Q_W + 1;

  // Viewport product: (33-bit signed) times (15-bit signed).
  localparam int VP_W = DATA_W + 1 + DIM_W + 1;

  localparam int FRONT_STAGES = 2;
  localparam int DIV_STAGES   = Q_W + 1;
  localparam int VP_STAGES    = 3;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + VP_STAGES;
  localparam int CNT_W        = $clog2(PIPE_DEPTH + 1);

  localparam int ADDR_W = 5;
  localparam int IDX_W  = ADDR_W - 2;
  localparam int BUS_W  = 32;

  localparam logic [IDX_W-1:0] REG_X_SCALE       = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_Y_SCALE       = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_DEPTH_SCALE   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_DEPTH_OFFSET  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_W_COEFFICIENT = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = IDX_W'(6);

  localparam logic [DATA_W-1:0] FX_ONE       = DATA_W'(1) << FRAC_BITS;
  localparam logic [DIM_W-1:0]  RST_WIDTH    = DIM_W'(640);
  localparam logic [DIM_W-1:0]  RST_HEIGHT   = DIM_W'(480);
  localparam logic [DATA_W-1:0] SAT_MAX      = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN      = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [Q_W-1:0]    NEG_MAX_MAG  = Q_W'(1) << (Q_W - 1);

  typedef struct packed {
    logic [DATA_W-1:0] x_scale;
    logic [DATA_W-1:0] y_scale;
    logic [DATA_W-1:0] depth_scale;
    logic [DATA_W-1:0] depth_offset;
    logic [DATA_W-1:0] w_coefficient;
    logic [DIM_W-1:0]  screen_width;
    logic [DIM_W-1:0]  screen_height;
  } pvt_cfg_t;

  // One quotient under construction: partial remainder, quotient bits,
  // sign of the final result and the flag for a quotient of 2^Q_W or more.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             neg;
    logic             ovf;
  } pvt_lane_t;

  typedef struct packed {
    pvt_lane_t        x;
    pvt_lane_t        y;
    pvt_lane_t        d;
    logic [DEN_W-1:0] den;
    logic             wz;
  } pvt_div_t;

endpackage
`default_nettype wire

// ----- sv/pvt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pvt_front
// Projection products and divider setup: scales x, y and z, forms depth and
// w, and turns each quotient into an unsigned dividend, divisor and sign.
// ----------------------------------------------------------------------------
module pvt_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [pvt_pkg::DATA_W-1:0] in_point_x,
  input  wire logic signed [pvt_pkg::DATA_W-1:0] in_point_y,
  input  wire logic signed [pvt_pkg::DATA_W-1:0] in_point_z,
  input  wire pvt_pkg::pvt_cfg_t             cfg,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pvt_pkg::pvt_div_t                  out_item
);
  import pvt_pkg::*;

  logic                     en;
  logic [FRONT_STAGES-1:0]  v_r;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r, prod_d_r, prod_w_r;
  logic signed [PROD_W-1:0] prod_x_nxt, prod_y_nxt, prod_d_nxt, prod_w_nxt;
  logic [SCL_W:0]           xs, ys, ds;
  logic [SCL_W-1:0]         ws;
  logic                     wz;
  pvt_div_t                 item_r, item_nxt;

  // Magnitude, dividend alignment and result sign of one quotient. With a
  // zero w the divisor is one and the value passes without the shift.
  function automatic pvt_lane_t make_lane(input logic [SCL_W:0] a, input logic zero_w,
                                          input logic w_neg);
    logic [SCL_W:0] mag;
    pvt_lane_t      l;
    mag   = a[SCL_W] ? (~a + 1'b1) : a;
    l.rem = NUM_W'(mag);
    if (!zero_w) begin
      l.rem = l.rem << FRAC_BITS;
    end
    l.quo = '0;
    l.neg = a[SCL_W] ^ (!zero_w && w_neg);
    l.ovf = 1'b0;
    return l;
  endfunction

  assign en       = !v_r[FRONT_STAGES-1] || out_ready;
  assign in_ready = en;

  always_comb begin
    prod_x_nxt = $signed(in_point_x) * $signed(cfg.x_scale);
    prod_y_nxt = $signed(in_point_y) * $signed(cfg.y_scale);
    prod_d_nxt = $signed(in_point_z) * $signed(cfg.depth_scale);
    prod_w_nxt = $signed(in_point_z) * $signed(cfg.w_coefficient);
  end

  // Dropping the low fraction bits of a two's complement product floors it.
  always_comb begin
    xs = {prod_x_r[PROD_W-1], prod_x_r[PROD_W-1:FRAC_BITS]};
    ys = {prod_y_r[PROD_W-1], prod_y_r[PROD_W-1:FRAC_BITS]};
    ds = {prod_d_r[PROD_W-1], prod_d_r[PROD_W-1:FRAC_BITS]}
       + {{(SCL_W+1-DATA_W){cfg.depth_offset[DATA_W-1]}}, cfg.depth_offset};
    ws = prod_w_r[PROD_W-1:FRAC_BITS];
    wz = (ws == '0);
    item_nxt.x  = make_lane(xs, wz, ws[SCL_W-1]);
    item_nxt.y  = make_lane(ys, wz, ws[SCL_W-1]);
    item_nxt.d  = make_lane(ds, wz, ws[SCL_W-1]);
    item_nxt.wz = wz;
    if (wz) begin
      item_nxt.den = DEN_W'(1);
    end else if (ws[SCL_W-1]) begin
      item_nxt.den = ~ws + 1'b1;
    end else begin
      item_nxt.den = ws;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[FRONT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      prod_d_r <= prod_d_nxt;
      prod_w_r <= prod_w_nxt;
      item_r   <= item_nxt;
    end
  end

  assign out_valid = v_r[FRONT_STAGES-1];
  assign out_item  = item_r;

endmodule
`default_nettype wire

// ----- sv/pvt_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pvt_divider
// Pipelined restoring divider for three quotients over a shared divisor:
// an overflow check stage, then one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module pvt_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pvt_pkg::pvt_div_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pvt_pkg::pvt_div_t      out_item
);
  import pvt_pkg::*;

  logic                  en;
  logic [DIV_STAGES-1:0] v_r;
  pvt_div_t              st_r   [DIV_STAGES];
  pvt_div_t              st_nxt [DIV_STAGES];

  // A quotient of 2^Q_W or more is flagged here; the result saturates then.
  function automatic pvt_div_t ovf_check(input pvt_div_t d);
    logic [CMP_W-1:0] lim;
    pvt_div_t         r;
    lim   = CMP_W'(d.den) << Q_W;
    r     = d;
    r.x.ovf = (CMP_W'(d.x.rem) >= lim);
    r.y.ovf = (CMP_W'(d.y.rem) >= lim);
    r.d.ovf = (CMP_W'(d.d.rem) >= lim);
    return r;
  endfunction

  function automatic pvt_lane_t lane_step(input pvt_lane_t l, input logic [DEN_W-1:0] den,
                                          input logic [QB_W-1:0] bitpos);
    logic [CMP_W-1:0] sh;
    logic             ge;
    pvt_lane_t        r;
    sh = CMP_W'(den) << bitpos;
    ge = (CMP_W'(l.rem) >= sh);
    r  = l;
    if (ge) begin
      r.rem = l.rem - sh[NUM_W-1:0];
    end
    r.quo[bitpos] = ge;
    return r;
  endfunction

  function automatic pvt_div_t div_step(input pvt_div_t d, input logic [QB_W-1:0] bitpos);
    pvt_div_t r;
    r   = d;
    r.x = lane_step(d.x, d.den, bitpos);
    r.y = lane_step(d.y, d.den, bitpos);
    r.d = lane_step(d.d, d.den, bitpos);
    return r;
  endfunction

  assign en       = !v_r[DIV_STAGES-1] || out_ready;
  assign in_ready = en;

  assign st_nxt[0] = ovf_check(in_item);

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_bit
    localparam int BITPOS = Q_W - k;
    assign st_nxt[k] = div_step(st_r[k-1], QB_W'(BITPOS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_item  = st_r[DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- sv/pvt_viewport.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pvt_viewport
// Saturates the quotients, then maps x and y onto the screen, flipping y
// against the height. The last stage is the result register.
// ----------------------------------------------------------------------------
module pvt_viewport (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire pvt_pkg::pvt_div_t         in_item,
  input  wire pvt_pkg::pvt_cfg_t         cfg,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [pvt_pkg::DATA_W-1:0]     out_screen_x,
  output logic [pvt_pkg::DATA_W-1:0]     out_screen_y,
  output logic [pvt_pkg::DATA_W-1:0]     out_depth,
  output logic                           out_w_was_zero
);
  import pvt_pkg::*;

  logic                    en;
  logic [VP_STAGES-1:0]    v_r;
  logic [DATA_W-1:0]       xd_r, yd_r, dd1_r, dd2_r, dd3_r;
  logic [DATA_W-1:0]       xd_nxt, yd_nxt, dd1_nxt;
  logic                    wz1_r, wz2_r, wz3_r;
  logic signed [DATA_W:0]  xo, yo;
  logic signed [VP_W-1:0]  mx_r, my_r, mx_nxt, my_nxt;
  logic signed [VP_W-1:0]  hx, hy;
  logic [VP_W:0]           sx_wide, sy_wide, h_one;
  logic [DATA_W-1:0]       sx_r, sy_r, sx_nxt, sy_nxt;

  function automatic logic [DATA_W-1:0] sat_quo(input pvt_lane_t l);
    logic [DATA_W-1:0] r;
    if (!l.neg) begin
      r = (l.ovf || l.quo[Q_W-1]) ? SAT_MAX : l.quo;
    end else begin
      r = (l.ovf || (l.quo > NEG_MAX_MAG)) ? SAT_MIN : (~l.quo + 1'b1);
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] sat_wide(input logic [VP_W:0] v);
    logic [DATA_W-1:0] r;
    if ((v[VP_W:DATA_W-1] == '0) || (v[VP_W:DATA_W-1] == '1)) begin
      r = v[DATA_W-1:0];
    end else begin
      r = v[VP_W] ? SAT_MIN : SAT_MAX;
    end
    return r;
  endfunction

  assign en       = !v_r[VP_STAGES-1] || out_ready;
  assign in_ready = en;

  always_comb begin
    xd_nxt  = sat_quo(in_item.x);
    yd_nxt  = sat_quo(in_item.y);
    dd1_nxt = sat_quo(in_item.d);
  end

  always_comb begin
    xo     = $signed({xd_r[DATA_W-1], xd_r}) + $signed({1'b0, FX_ONE});
    yo     = $signed({yd_r[DATA_W-1], yd_r}) + $signed({1'b0, FX_ONE});
    mx_nxt = xo * $signed({1'b0, cfg.screen_width});
    my_nxt = yo * $signed({1'b0, cfg.screen_height});
  end

  // Arithmetic shift by one is the floor of half the product.
  always_comb begin
    hx      = mx_r >>> 1;
    hy      = my_r >>> 1;
    h_one   = (VP_W+1)'(cfg.screen_height) << FRAC_BITS;
    sx_wide = {hx[VP_W-1], hx};
    sy_wide = h_one - {hy[VP_W-1], hy};
    sx_nxt  = sat_wide(sx_wide);
    sy_nxt  = sat_wide(sy_wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[VP_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xd_r  <= xd_nxt;
      yd_r  <= yd_nxt;
      dd1_r <= dd1_nxt;
      wz1_r <= in_item.wz;
      mx_r  <= mx_nxt;
      my_r  <= my_nxt;
      dd2_r <= dd1_r;
      wz2_r <= wz1_r;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      dd3_r <= dd2_r;
      wz3_r <= wz2_r;
    end
  end

  assign out_valid      = v_r[VP_STAGES-1];
  assign out_screen_x   = sx_r;
  assign out_screen_y   = sy_r;
  assign out_depth      = dd3_r;
  assign out_w_was_zero = wz3_r;

endmodule
`default_nettype wire

// ----- sv/perspective_viewport_transform.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// perspective_viewport_transform
// Perspective projection and viewport mapping of Q16.16 vertices.
// ----------------------------------------------------------------------------
// A vertex request enters on the in_ channel (valid/ready) and its screen
// position, depth and zero-w flag leave on the out_ channel. Each request
// yields exactly one result, in order.
// From acceptance to out_valid a request passes the front section, which
// forms the projection products and divider setup, the divider (an overflow
// check, then one quotient bit per stage over 32 stages) and the viewport
// section for saturation and the viewport mapping. The divider is the
// deepest section. Throughput is one vertex per cycle while the receiver does not stall.
// When the receiver stalls, the result stays in the output register. The
// front, divider and viewport sections each hold all their stages, bubbles
// included, once their own last stage holds a request that cannot move on,
// so the input stalls when the front section is blocked that way.
// Reset clears all request valid bits and loads the register defaults:
// scales and w coefficient 1.0, depth offset 0, viewport 640 by 480.
// Registers are written over the APB port at byte address 4*i, and should
// be written only while no request is in flight.
// ----------------------------------------------------------------------------
module perspective_viewport_transform (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [pvt_pkg::DATA_W-1:0] in_point_x,
  input  wire logic signed [pvt_pkg::DATA_W-1:0] in_point_y,
  input  wire logic signed [pvt_pkg::DATA_W-1:0] in_point_z,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [pvt_pkg::DATA_W-1:0]      out_screen_x,
  output logic signed [pvt_pkg::DATA_W-1:0]      out_screen_y,
  output logic signed [pvt_pkg::DATA_W-1:0]      out_depth,
  output logic                                   out_w_was_zero,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pvt_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [pvt_pkg::BUS_W-1:0]         pwdata,
  output logic [pvt_pkg::BUS_W-1:0]              prdata,
  output logic                                   pready
);
  import pvt_pkg::*;

  pvt_cfg_t          cfg_r, cfg_nxt;
  logic              wr;
  logic [IDX_W-1:0]  idx;
  logic              fr_valid, fr_ready, dv_valid, dv_ready;
  pvt_div_t          fr_item, dv_item;
  logic [DATA_W-1:0] vp_sx, vp_sy, vp_dd;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_X_SCALE:       cfg_nxt.x_scale       = pwdata[DATA_W-1:0];
        REG_Y_SCALE:       cfg_nxt.y_scale       = pwdata[DATA_W-1:0];
        REG_DEPTH_SCALE:   cfg_nxt.depth_scale   = pwdata[DATA_W-1:0];
        REG_DEPTH_OFFSET:  cfg_nxt.depth_offset  = pwdata[DATA_W-1:0];
        REG_W_COEFFICIENT: cfg_nxt.w_coefficient = pwdata[DATA_W-1:0];
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = pwdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height = pwdata[DIM_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_scale       <= FX_ONE;
      cfg_r.y_scale       <= FX_ONE;
      cfg_r.depth_scale   <= FX_ONE;
      cfg_r.depth_offset  <= '0;
      cfg_r.w_coefficient <= FX_ONE;
      cfg_r.screen_width  <= RST_WIDTH;
      cfg_r.screen_height <= RST_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_X_SCALE:       prdata = BUS_W'(cfg_r.x_scale);
      REG_Y_SCALE:       prdata = BUS_W'(cfg_r.y_scale);
      REG_DEPTH_SCALE:   prdata = BUS_W'(cfg_r.depth_scale);
      REG_DEPTH_OFFSET:  prdata = BUS_W'(cfg_r.depth_offset);
      REG_W_COEFFICIENT: prdata = BUS_W'(cfg_r.w_coefficient);
      REG_SCREEN_WIDTH:  prdata = BUS_W'(cfg_r.screen_width);
      REG_SCREEN_HEIGHT: prdata = BUS_W'(cfg_r.screen_height);
      default:           prdata = '0;
    endcase
  end

  pvt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_point_z (in_point_z),
    .cfg        (cfg_r),
    .out_valid  (fr_valid),
    .out_ready  (fr_ready),
    .out_item   (fr_item)
  );

  pvt_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_item   (fr_item),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_item  (dv_item)
  );

  pvt_viewport u_viewport (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (dv_valid),
    .in_ready       (dv_ready),
    .in_item        (dv_item),
    .cfg            (cfg_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_screen_x   (vp_sx),
    .out_screen_y   (vp_sy),
    .out_depth      (vp_dd),
    .out_w_was_zero (out_w_was_zero)
  );

  assign out_screen_x = $signed(vp_sx);
  assign out_screen_y = $signed(vp_sy);
  assign out_depth    = $signed(vp_dd);

  // Requests accepted and not yet delivered.
  assign cnt_nxt = cnt_r + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while no result is waiting");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != '0))
    else $error("result presented with no request in flight");

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
